[sv/rpq_pkg.sv]
// Shared constants, types and GF(2^8) helpers for the RAID-6 rebuild engine.
package rpq_pkg;

  // Array geometry and field widths
  localparam int MAX_COLUMNS = 16;
  localparam int COL_W       = 4;
  localparam int DC_W        = 5;
  localparam int BYTE_W      = 8;

  // GF(2^8) reduction polynomial, low eight bits (x^8 term implied)
  localparam logic [BYTE_W-1:0] GF_POLY_LO = 8'h1d;

  // Inverse by x^254: one square and one multiply per step
  localparam int INV_STEPS = BYTE_W - 1;

  // Position-summary queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register map
  localparam int REG_NUM    = 3;
  localparam int REG_IDX_W  = $clog2(REG_NUM);
  localparam int PADDR_W    = REG_IDX_W + 2;
  localparam int PDATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] REG_DISK_COUNT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_FAILED  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_FAILED = 2'd2;

  localparam logic [DC_W-1:0]  DISK_COUNT_RST    = 5'd4;
  localparam logic [COL_W-1:0] FIRST_FAILED_RST  = 4'd0;
  localparam logic [COL_W-1:0] SECOND_FAILED_RST = 4'd1;

  typedef struct packed {
    logic [DC_W-1:0]  disk_count;
    logic [COL_W-1:0] first_failed;
    logic [COL_W-1:0] second_failed;
  } rpq_cfg_t;

  // Per-position summary handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] xor_sum;
    logic [BYTE_W-1:0] weighted_sum;
    logic [BYTE_W-1:0] parity_p;
    logic [BYTE_W-1:0] parity_q;
    logic              end_of_stripe;
  } rpq_entry_t;

  // GF(2^8) multiply, shift-and-add over the eight bits of b
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] x;
    acc = '0;
    x   = a;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) acc = acc ^ x;
      x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY_LO : '0);
    end
    return acc;
  endfunction

  // Generator powers 2^e for a column index
  function automatic logic [BYTE_W-1:0] gf_pow2(input logic [COL_W-1:0] e);
    logic [BYTE_W-1:0] v;
    case (e)
      4'd0:    v = 8'h01;
      4'd1:    v = 8'h02;
      4'd2:    v = 8'h04;
      4'd3:    v = 8'h08;
      4'd4:    v = 8'h10;
      4'd5:    v = 8'h20;
      4'd6:    v = 8'h40;
      4'd7:    v = 8'h80;
      4'd8:    v = 8'h1d;
      4'd9:    v = 8'h3a;
      4'd10:   v = 8'h74;
      4'd11:   v = 8'he8;
      4'd12:   v = 8'hcd;
      4'd13:   v = 8'h87;
      4'd14:   v = 8'h13;
      4'd15:   v = 8'h26;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

  // Effective column count, saturated to 3..MAX_COLUMNS
  function automatic logic [DC_W-1:0] clamp_count(input logic [DC_W-1:0] dc);
    logic [DC_W-1:0] n;
    if (dc < DC_W'(3)) n = DC_W'(3);
    else if (dc > DC_W'(MAX_COLUMNS)) n = DC_W'(MAX_COLUMNS);
    else n = dc;
    return n;
  endfunction

endpackage

[sv/rpq_if.sv]
// Valid/ready channel interfaces for column input and rebuilt results.
interface rpq_in_if import rpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column_index;
  logic [BYTE_W-1:0] column_byte;
  logic             last_column;
  logic             last_position;

  modport source (output valid, column_index, column_byte, last_column, last_position,
                  input ready);
  modport sink   (input valid, column_index, column_byte, last_column, last_position,
                  output ready);
endinterface

interface rpq_out_if import rpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_value;
  logic [BYTE_W-1:0] second_value;
  logic              end_of_stripe;

  modport source (output valid, first_value, second_value, end_of_stripe, input ready);
  modport sink   (input valid, first_value, second_value, end_of_stripe, output ready);
endinterface

[sv/raid6_pq_syndrome_recovery.sv]
// Top level of the RAID-6 P+Q rebuild engine.
// Column bytes of one byte position stream in on in_ch, one transfer per cycle,
// data columns first, then P, then Q; the transfer flagged last_column closes the
// position and yields one result on out_ch with the rebuilt bytes of the two
// failed columns (a data column is reported ahead of a parity column). The front
// end takes a byte every cycle while the queue has room and folds it into XOR and
// 2^column-weighted sums; a two-entry queue then feeds a back-end sequencer with
// two GF(2^8) multipliers; the sequencer takes a new position only when idle. Both
// parities, or a data column plus Q, are rebuilt directly; data plus P, or two
// data columns, need a GF inverse, formed as x^254 in 7 square-and-multiply steps.
// in_ch only stalls when the queue is full. Configure disk_count, first_failed and
// second_failed over APB (byte addresses 0x0, 0x4, 0x8) while the engine is idle.
module raid6_pq_syndrome_recovery import rpq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rpq_in_if.sink             in_ch,
  rpq_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  rpq_cfg_t   cfg;
  logic       push_valid;
  logic       push_ready;
  rpq_entry_t push_entry;
  logic       pop_valid;
  logic       pop_ready;
  rpq_entry_t pop_entry;

  rpq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  rpq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  rpq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

[sv/rpq_cfg.sv]
// APB configuration registers: disk count and the two failed columns.
module rpq_cfg import rpq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output rpq_cfg_t           cfg
);

  logic [DC_W-1:0]      disk_count_r;
  logic [COL_W-1:0]     first_failed_r;
  logic [COL_W-1:0]     second_failed_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_count_r    <= DISK_COUNT_RST;
      first_failed_r  <= FIRST_FAILED_RST;
      second_failed_r <= SECOND_FAILED_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DISK_COUNT:    disk_count_r    <= pwdata[DC_W-1:0];
        REG_FIRST_FAILED:  first_failed_r  <= pwdata[COL_W-1:0];
        REG_SECOND_FAILED: second_failed_r <= pwdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_DISK_COUNT:    prdata = PDATA_W'(disk_count_r);
      REG_FIRST_FAILED:  prdata = PDATA_W'(first_failed_r);
      REG_SECOND_FAILED: prdata = PDATA_W'(second_failed_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.disk_count    = disk_count_r;
  assign cfg.first_failed  = first_failed_r;
  assign cfg.second_failed = second_failed_r;

endmodule

[sv/rpq_front.sv]
// Front end: takes column bytes, classifies them and builds the per-position sums.
module rpq_front import rpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  rpq_cfg_t   cfg,
  rpq_in_if.sink     in_ch,
  output logic       push_valid,
  output rpq_entry_t push_entry,
  input  logic       push_ready
);

  logic [BYTE_W-1:0] xor_acc_r,  xor_acc_nxt;
  logic [BYTE_W-1:0] wsum_acc_r, wsum_acc_nxt;
  logic [BYTE_W-1:0] parity_p_r, parity_p_nxt;

  logic [DC_W-1:0]   n_cols;
  logic [DC_W-1:0]   n_data;
  logic [DC_W-1:0]   col_ext;
  logic              live;
  logic              is_data;
  logic              is_p;
  logic              is_q;
  logic              xfer;
  logic [BYTE_W-1:0] xor_new;
  logic [BYTE_W-1:0] wsum_new;

  assign n_cols  = clamp_count(cfg.disk_count);
  assign n_data  = n_cols - DC_W'(2);
  assign col_ext = DC_W'(in_ch.column_index);

  // Classify: skip failed and out-of-array columns, then data / P / Q
  assign live    = (in_ch.column_index != cfg.first_failed) &&
                   (in_ch.column_index != cfg.second_failed) && (col_ext < n_cols);
  assign is_data = live && (col_ext < n_data);
  assign is_p    = live && (col_ext == n_data);
  assign is_q    = live && (col_ext > n_data);

  assign in_ch.ready = push_ready;
  assign xfer        = in_ch.valid & in_ch.ready;

  // Fold this byte into the sums
  assign xor_new  = xor_acc_r ^ (is_data ? in_ch.column_byte : '0);
  assign wsum_new = wsum_acc_r ^
                    (is_data ? gf_mul(gf_pow2(in_ch.column_index), in_ch.column_byte) : '0);

  always_comb begin
    xor_acc_nxt  = xor_acc_r;
    wsum_acc_nxt = wsum_acc_r;
    parity_p_nxt = parity_p_r;
    if (xfer) begin
      parity_p_nxt = is_p ? in_ch.column_byte : parity_p_r;
      // Clear the sums at the end of each position
      xor_acc_nxt  = in_ch.last_column ? '0 : xor_new;
      wsum_acc_nxt = in_ch.last_column ? '0 : wsum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_acc_r  <= '0;
      wsum_acc_r <= '0;
      parity_p_r <= '0;
    end else begin
      xor_acc_r  <= xor_acc_nxt;
      wsum_acc_r <= wsum_acc_nxt;
      parity_p_r <= parity_p_nxt;
    end
  end

  // Hand the finished position to the back end
  assign push_valid               = xfer & in_ch.last_column;
  assign push_entry.xor_sum       = xor_new;
  assign push_entry.weighted_sum  = wsum_new;
  assign push_entry.parity_p      = is_p ? in_ch.column_byte : parity_p_r;
  assign push_entry.parity_q      = is_q ? in_ch.column_byte : '0;
  assign push_entry.end_of_stripe = in_ch.last_position;

endmodule

[sv/rpq_queue.sv]
// Short FIFO of position summaries between the front and back ends.
module rpq_queue import rpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  rpq_entry_t push_entry,
  output logic       push_ready,
  output logic       pop_valid,
  output rpq_entry_t pop_entry,
  input  logic       pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rpq_entry_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

[sv/rpq_back.sv]
// Back end: rebuilds the two failed columns from a position summary.
module rpq_back import rpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  rpq_cfg_t   cfg,
  input  logic       pop_valid,
  input  rpq_entry_t pop_entry,
  output logic       pop_ready,
  rpq_out_if.source  out_ch
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_INV   = 3'd2;
  localparam logic [2:0] ST_SOLVE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Failure cases
  localparam logic [1:0] MODE_PP = 2'd0;  // both parities
  localparam logic [1:0] MODE_DQ = 2'd1;  // data and Q: rebuild from P
  localparam logic [1:0] MODE_DP = 2'd2;  // data and P: rebuild from Q
  localparam logic [1:0] MODE_DD = 2'd3;  // two data columns

  localparam int STEP_W = $clog2(INV_STEPS);

  logic [2:0]        state_r,   state_nxt;
  rpq_entry_t        ent_r,     ent_nxt;
  logic [BYTE_W-1:0] num_r,     num_nxt;
  logic [BYTE_W-1:0] pow_r,     pow_nxt;
  logic [BYTE_W-1:0] sq_r,      sq_nxt;
  logic [STEP_W-1:0] step_r,    step_nxt;
  logic [BYTE_W-1:0] res_a_r,   res_a_nxt;
  logic [BYTE_W-1:0] res_b_r,   res_b_nxt;
  logic              ovalid_r,  ovalid_nxt;
  logic [BYTE_W-1:0] oa_r,      oa_nxt;
  logic [BYTE_W-1:0] ob_r,      ob_nxt;
  logic              oeos_r,    oeos_nxt;

  logic [DC_W-1:0]   n_cols;
  logic [DC_W-1:0]   n_data;
  logic [DC_W-1:0]   q_col;
  logic [DC_W-1:0]   fa0, fb0, fa, fb;
  logic              swap;
  logic [1:0]        mode;
  logic [BYTE_W-1:0] ga, gb, divisor;
  logic [BYTE_W-1:0] pxy, qxy;
  logic [BYTE_W-1:0] m0_a, m0_b, m1_a, m1_b, m0, m1;
  logic              out_free;

  // Normalize the failed pair: a data column comes first
  assign n_cols = clamp_count(cfg.disk_count);
  assign n_data = n_cols - DC_W'(2);
  assign q_col  = n_cols - DC_W'(1);
  assign fa0    = DC_W'(cfg.first_failed);
  assign fb0    = DC_W'(cfg.second_failed);
  assign swap   = (fa0 >= n_data) && (fb0 < n_data);
  assign fa     = swap ? fb0 : fa0;
  assign fb     = swap ? fa0 : fb0;

  always_comb begin
    if (fa >= n_data)     mode = MODE_PP;
    else if (fb == q_col) mode = MODE_DQ;
    else if (fb >= n_data) mode = MODE_DP;
    else                  mode = MODE_DD;
  end

  assign ga      = gf_pow2(fa[COL_W-1:0]);
  assign gb      = gf_pow2(fb[COL_W-1:0]);
  assign divisor = (mode == MODE_DP) ? ga : (ga ^ gb);
  assign pxy     = ent_r.parity_p ^ ent_r.xor_sum;
  assign qxy     = ent_r.parity_q ^ ent_r.weighted_sum;

  // Two GF multipliers shared across the sequence
  always_comb begin
    m0_a = '0;
    m0_b = '0;
    m1_a = '0;
    m1_b = '0;
    case (state_r)
      ST_MUL: begin
        m0_a = ga;
        m0_b = pxy;
        m1_a = divisor;
        m1_b = divisor;
      end
      ST_INV: begin
        m0_a = pow_r;
        m0_b = sq_r;
        m1_a = sq_r;
        m1_b = sq_r;
      end
      ST_SOLVE: begin
        m0_a = pow_r;
        m0_b = num_r;
      end
      default: ;
    endcase
  end

  assign m0 = gf_mul(m0_a, m0_b);
  assign m1 = gf_mul(m1_a, m1_b);

  assign pop_ready = (state_r == ST_IDLE);
  assign out_free  = !ovalid_r || out_ch.ready;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    ent_nxt    = ent_r;
    num_nxt    = num_r;
    pow_nxt    = pow_r;
    sq_nxt     = sq_r;
    step_nxt   = step_r;
    res_a_nxt  = res_a_r;
    res_b_nxt  = res_b_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    oa_nxt     = oa_r;
    ob_nxt     = ob_r;
    oeos_nxt   = oeos_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          ent_nxt   = pop_entry;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // Start the x^254 inverse: pow = 1, sq = d^2
        pow_nxt  = 8'h01;
        sq_nxt   = m1;
        step_nxt = '0;
        case (mode)
          MODE_PP: begin
            res_a_nxt = (fa == q_col) ? ent_r.weighted_sum : ent_r.xor_sum;
            res_b_nxt = (fb == q_col) ? ent_r.weighted_sum : ent_r.xor_sum;
            state_nxt = ST_DONE;
          end
          MODE_DQ: begin
            res_a_nxt = pxy;
            res_b_nxt = ent_r.weighted_sum ^ m0;
            state_nxt = ST_DONE;
          end
          MODE_DP: begin
            num_nxt   = qxy;
            state_nxt = ST_INV;
          end
          default: begin
            num_nxt   = m0 ^ qxy;
            state_nxt = ST_INV;
          end
        endcase
      end
      ST_INV: begin
        pow_nxt  = m0;
        sq_nxt   = m1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(INV_STEPS - 1)) state_nxt = ST_SOLVE;
      end
      ST_SOLVE: begin
        if (mode == MODE_DP) begin
          res_a_nxt = m0;
          res_b_nxt = ent_r.xor_sum ^ m0;
        end else begin
          res_b_nxt = m0;
          res_a_nxt = pxy ^ m0;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register frees up
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oa_nxt     = res_a_r;
          ob_nxt     = res_b_r;
          oeos_nxt   = ent_r.end_of_stripe;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      step_r   <= step_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    num_r   <= num_nxt;
    pow_r   <= pow_nxt;
    sq_r    <= sq_nxt;
    res_a_r <= res_a_nxt;
    res_b_r <= res_b_nxt;
    oa_r    <= oa_nxt;
    ob_r    <= ob_nxt;
    oeos_r  <= oeos_nxt;
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.first_value   = oa_r;
  assign out_ch.second_value  = ob_r;
  assign out_ch.end_of_stripe = oeos_r;

endmodule

[sv/rpq_checker.sv]
// Port-level assertions for the rebuild engine and their bind to the top level.
module rpq_checker import rpq_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last_column,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_first_value,
  input logic [BYTE_W-1:0] out_second_value,
  input logic              out_end_of_stripe
);

  // Positions closed on the input side but not yet delivered
  logic [2:0] pending_r, pending_nxt;
  logic       in_close;
  logic       out_xfer;

  assign in_close = in_valid & in_ready & in_last_column;
  assign out_xfer = out_valid & out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_close && !out_xfer) pending_nxt = pending_r + 3'd1;
    else if (!in_close && out_xfer) pending_nxt = pending_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pending_r <= '0;
    else pending_r <= pending_nxt;
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_value) &&
    $stable(out_second_value) && $stable(out_end_of_stripe))
    else $error("stalled result changed");

  a_out_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without a closed position");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("more positions in flight than the engine can hold");

endmodule

bind raid6_pq_syndrome_recovery rpq_checker u_rpq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_last_column    (in_ch.last_column),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_first_value   (out_ch.first_value),
  .out_second_value  (out_ch.second_value),
  .out_end_of_stripe (out_ch.end_of_stripe)
);

[dv/tb.sv]
// Testbench for the RAID-6 P+Q rebuild engine: column streams checked against a GF(2^8) predictor.
`timescale 1ns / 100ps

module tb;
  import rpq_pkg::*;

  localparam int IDLE_PCT      = 13;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASES        = 8;
  localparam int PHASE_COLUMNS = 130;

  typedef struct packed {
    logic [COL_W-1:0]  column_index;
    logic [BYTE_W-1:0] column_byte;
    logic              last_column;
    logic              last_position;
  } column_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first_value;
    logic [BYTE_W-1:0] second_value;
    logic              end_of_stripe;
  } rebuild_t;

  typedef enum logic {ROW_WRITE, ROW_COLUMN} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [REG_IDX_W-1:0] reg_idx;
    int unsigned          reg_value;
    column_t              column;
    bit                   typed;
    rebuild_t             want;
  } script_row_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rpq_in_if  col_bus ();
  rpq_out_if rebuild_bus ();

  raid6_pq_syndrome_recovery dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (col_bus),
    .out_ch  (rebuild_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and the per-position sums
  logic [DC_W-1:0]   cfg_disk_count;
  logic [COL_W-1:0]  cfg_first;
  logic [COL_W-1:0]  cfg_second;
  logic [BYTE_W-1:0] xor_sum;
  logic [BYTE_W-1:0] weighted_sum;
  logic [BYTE_W-1:0] held_p;

  rebuild_t    pending_rebuilds[$];
  script_row_t script[$];
  int          mismatches   = 0;
  int          columns_sent = 0;
  int          quiet_cycles = 0;
  bit          steady       = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // GF(2^8) multiply, polynomial 0x11d
  function automatic logic [BYTE_W-1:0] gf_product(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0]   x;
    logic [BYTE_W-1:0] acc;
    int                i;
    acc = '0;
    x   = {1'b0, a};
    for (i = 0; i < BYTE_W; i++) begin
      if (b[i]) acc ^= x[BYTE_W-1:0];
      x = x << 1;
      if (x[BYTE_W]) x ^= 9'h11d;
    end
    return acc;
  endfunction

  function automatic logic [BYTE_W-1:0] gen_power(input int unsigned e);
    logic [BYTE_W-1:0] x;
    int unsigned       i;
    x = 8'h01;
    for (i = 0; i < e % 255; i++) x = gf_product(x, 8'h02);
    return x;
  endfunction

  // x^254; zero maps to zero
  function automatic logic [BYTE_W-1:0] gf_inverse(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    int                i;
    r = 8'h01;
    for (i = 0; i < 254; i++) r = gf_product(r, v);
    return r;
  endfunction

  // Fold one column byte into the sums; on last_column compute the rebuilt pair
  function automatic bit fold_column(input column_t c, output rebuild_t r);
    int unsigned       n, nd, col, fa, fb, t;
    logic [BYTE_W-1:0] q_operand, va, vb, ga, gb, pxy, qxy;
    n = 32'(cfg_disk_count);
    if (n < 3) n = 3;
    if (n > MAX_COLUMNS) n = MAX_COLUMNS;
    nd        = n - 2;
    col       = 32'(c.column_index);
    q_operand = '0;
    r         = '0;
    if (col != cfg_first && col != cfg_second && col < n) begin
      if (col < nd) begin
        xor_sum      ^= c.column_byte;
        weighted_sum ^= gf_product(gen_power(col), c.column_byte);
      end else if (col == nd) begin
        held_p = c.column_byte;
      end else begin
        q_operand = c.column_byte;
      end
    end
    if (!c.last_column) return 1'b0;

    // Put a data column ahead of a parity column
    fa = 32'(cfg_first);
    fb = 32'(cfg_second);
    if (fa >= nd && fb < nd) begin
      t  = fa;
      fa = fb;
      fb = t;
    end

    if (fa >= nd) begin
      // both parities lost (an index past the array counts as P)
      va = (fa == n - 1) ? weighted_sum : xor_sum;
      vb = (fb == n - 1) ? weighted_sum : xor_sum;
    end else if (fb >= nd) begin
      ga = gen_power(fa);
      if (fb == n - 1) begin
        // data from P, then regenerate Q
        va = held_p ^ xor_sum;
        vb = weighted_sum ^ gf_product(ga, va);
      end else begin
        // data from Q, then regenerate P
        va = gf_product(q_operand ^ weighted_sum, gf_inverse(ga));
        vb = xor_sum ^ va;
      end
    end else begin
      // two data columns: solve the P/Q pair
      ga  = gen_power(fa);
      gb  = gen_power(fb);
      pxy = held_p ^ xor_sum;
      qxy = q_operand ^ weighted_sum;
      vb  = gf_product(gf_product(pxy, ga) ^ qxy, gf_inverse(ga ^ gb));
      va  = pxy ^ vb;
    end

    xor_sum         = '0;
    weighted_sum    = '0;
    r.first_value   = va;
    r.second_value  = vb;
    r.end_of_stripe = c.last_position;
    return 1'b1;
  endfunction

  function automatic column_t pack_column(input int unsigned c, input int unsigned b,
                                          input bit l, input bit p);
    column_t x;
    x.column_index  = COL_W'(c);
    x.column_byte   = BYTE_W'(b);
    x.last_column   = l;
    x.last_position = p;
    return x;
  endfunction

  function automatic script_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                            input int unsigned value);
    script_row_t row;
    row           = '{kind: ROW_WRITE, default: '0};
    row.kind      = ROW_WRITE;
    row.reg_idx   = idx;
    row.reg_value = value;
    return row;
  endfunction

  function automatic script_row_t column_row(input int unsigned c, input int unsigned b,
                                             input bit l, input bit p);
    script_row_t row;
    row        = '{kind: ROW_COLUMN, default: '0};
    row.kind   = ROW_COLUMN;
    row.column = pack_column(c, b, l, p);
    return row;
  endfunction

  function automatic script_row_t checked_row(input int unsigned c, input int unsigned b,
                                              input bit l, input bit p,
                                              input int unsigned first_v,
                                              input int unsigned second_v, input bit eos);
    script_row_t row;
    row       = column_row(c, b, l, p);
    row.typed = 1'b1;
    row.want  = '{BYTE_W'(first_v), BYTE_W'(second_v), eos};
    return row;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns rebuild mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Drive one column transfer; entered and left at a falling edge
  task automatic send_column(input column_t c, input bit typed, input rebuild_t want);
    rebuild_t r;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      col_bus.valid <= 1'b0;
      @(negedge clk);
    end
    col_bus.valid         <= 1'b1;
    col_bus.column_index  <= c.column_index;
    col_bus.column_byte   <= c.column_byte;
    col_bus.last_column   <= c.last_column;
    col_bus.last_position <= c.last_position;
    do @(posedge clk); while (!col_bus.ready);
    columns_sent++;
    if (fold_column(c, r)) pending_rebuilds.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected result is out, then wait extra cycles
  task automatic settle(input int unsigned extra);
    col_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_rebuilds.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DISK_COUNT:    cfg_disk_count = DC_W'(value);
      REG_FIRST_FAILED:  cfg_first      = COL_W'(value);
      REG_SECOND_FAILED: cfg_second     = COL_W'(value);
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Result side stalls at random except during the steady stretch
  always @(negedge clk) begin
    rebuild_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    rebuild_t got;
    rebuild_t want;
    if (rst_n && rebuild_bus.valid && rebuild_bus.ready) begin
      got = '{rebuild_bus.first_value, rebuild_bus.second_value, rebuild_bus.end_of_stripe};
      if (pending_rebuilds.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h/%h eos %b",
                                  got.first_value, got.second_value, got.end_of_stripe));
      end else begin
        want = pending_rebuilds.pop_front();
        if (got.first_value !== want.first_value)
          report_mismatch($sformatf("first_value %h, want %h",
                                    got.first_value, want.first_value));
        if (got.second_value !== want.second_value)
          report_mismatch($sformatf("second_value %h, want %h",
                                    got.second_value, want.second_value));
        if (got.end_of_stripe !== want.end_of_stripe)
          report_mismatch($sformatf("end_of_stripe %b, want %b",
                                    got.end_of_stripe, want.end_of_stripe));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((col_bus.valid && col_bus.ready) || (rebuild_bus.valid && rebuild_bus.ready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("raid6_pq_syndrome_recovery verification failed");
      $finish;
    end
  end

  initial begin
    rebuild_t    none;
    int unsigned dc, fa, fb, n_cols, k, len, start, positions, phase;
    bit          eos;

    none                  = '0;
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    col_bus.valid         = 1'b0;
    col_bus.column_index  = '0;
    col_bus.column_byte   = '0;
    col_bus.last_column   = 1'b0;
    col_bus.last_position = 1'b0;
    rebuild_bus.ready     = 1'b0;

    cfg_disk_count = DISK_COUNT_RST;
    cfg_first      = FIRST_FAILED_RST;
    cfg_second     = SECOND_FAILED_RST;
    xor_sum        = '0;
    weighted_sum   = '0;
    held_p         = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setup: four columns, data 0 and 1 lost
    script.push_back(column_row(2, 8'hff, 0, 0));
    script.push_back(checked_row(3, 8'hff, 1, 0, 8'hff, 8'h00, 0));
    script.push_back(column_row(0, 8'h5a, 0, 0));
    script.push_back(column_row(1, 8'ha5, 0, 0));
    script.push_back(column_row(2, 8'h00, 0, 0));
    script.push_back(checked_row(3, 8'h00, 1, 1, 8'h00, 8'h00, 1));
    // P missing: reuse the held P byte
    script.push_back(column_row(3, 8'hc3, 1, 0));
    // column past the array still closes the position
    script.push_back(column_row(15, 8'h12, 1, 1));
    // out of order and repeated; Q not on the closing step
    script.push_back(column_row(3, 8'h77, 0, 0));
    script.push_back(column_row(2, 8'h81, 0, 0));
    script.push_back(column_row(2, 8'h18, 1, 0));
    // count below range saturates to 3; both parities lost
    script.push_back(write_row(REG_DISK_COUNT, 0));
    script.push_back(write_row(REG_FIRST_FAILED, 2));
    script.push_back(write_row(REG_SECOND_FAILED, 1));
    script.push_back(checked_row(0, 8'h80, 1, 0, 8'h80, 8'h80, 0));
    script.push_back(column_row(0, 8'hff, 0, 0));
    script.push_back(column_row(1, 8'h33, 0, 0));
    script.push_back(checked_row(2, 8'h44, 1, 1, 8'hff, 8'hff, 1));
    // count above range saturates to 16; Q and data lost, swapped
    script.push_back(write_row(REG_DISK_COUNT, 31));
    script.push_back(write_row(REG_FIRST_FAILED, 15));
    script.push_back(write_row(REG_SECOND_FAILED, 3));
    script.push_back(column_row(0, 8'h01, 0, 0));
    script.push_back(column_row(14, 8'h5e, 0, 0));
    script.push_back(column_row(15, 8'h99, 1, 0));
    // P and data lost: rebuild from Q
    script.push_back(write_row(REG_DISK_COUNT, 16));
    script.push_back(write_row(REG_FIRST_FAILED, 14));
    script.push_back(write_row(REG_SECOND_FAILED, 0));
    script.push_back(column_row(1, 8'h6c, 0, 0));
    script.push_back(column_row(15, 8'he7, 1, 0));
    // failed index past the array acts as P
    script.push_back(write_row(REG_DISK_COUNT, 5));
    script.push_back(write_row(REG_FIRST_FAILED, 9));
    script.push_back(write_row(REG_SECOND_FAILED, 2));
    script.push_back(column_row(0, 8'h11, 0, 0));
    script.push_back(column_row(1, 8'h22, 0, 0));
    script.push_back(column_row(4, 8'h39, 1, 1));
    // equal failed data columns: zero divisor
    script.push_back(write_row(REG_DISK_COUNT, 6));
    script.push_back(write_row(REG_FIRST_FAILED, 1));
    script.push_back(write_row(REG_SECOND_FAILED, 1));
    script.push_back(column_row(0, 8'h00, 0, 0));
    script.push_back(column_row(4, 8'h3c, 0, 0));
    script.push_back(checked_row(5, 8'hab, 1, 0, 8'h3c, 8'h00, 0));

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle(SETTLE_CYCLES);
        write_register(script[i].reg_idx, script[i].reg_value);
      end else begin
        send_column(script[i].column, script[i].typed, script[i].want);
      end
    end

    // Random stripes under a series of array setups
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin dc = 3;  fa = 0;  fb = 1;  end
        1: begin dc = 16; fa = 12; fb = 13; end
        2: begin dc = 16; fa = 14; fb = 15; end
        3: begin dc = 10; fa = 9;  fb = 7;  end
        default: begin
          dc = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(16, 3);
          fa = $urandom_range(15);
          fb = $urandom_range(15);
        end
      endcase
      settle(SETTLE_CYCLES);
      write_register(REG_DISK_COUNT, dc);
      write_register(REG_FIRST_FAILED, fa);
      write_register(REG_SECOND_FAILED, fb);
      n_cols    = (dc < 3) ? 3 : (dc > MAX_COLUMNS) ? MAX_COLUMNS : dc;
      steady    = (phase == 4);
      start     = columns_sent;
      positions = 0;
      while (columns_sent - start < PHASE_COLUMNS) begin
        // hold the sender until the engine has drained
        if (positions == 6 && phase[0]) settle(0);
        if ($urandom_range(99) < 85) begin
          eos = ($urandom_range(5) == 0);
          for (k = 0; k < n_cols; k++)
            send_column(pack_column(k, $urandom_range(255), k == n_cols - 1, eos), 1'b0, none);
        end else begin
          // broken position: random columns, always closed by a last_column
          len = $urandom_range(n_cols, 1);
          for (k = 0; k < len; k++)
            send_column(pack_column($urandom_range(15), $urandom_range(255),
                                    (k == len - 1) || ($urandom_range(9) == 0),
                                    1'($urandom_range(1))), 1'b0, none);
        end
        positions++;
      end
    end
    steady = 1'b0;

    settle(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("raid6_pq_syndrome_recovery verification clean");
    end else begin
      $display("raid6_pq_syndrome_recovery verification failed");
    end
    $finish;
  end

endmodule
